@@ src/sadl_pkg.sv @@
// Package for the slot allocator with a dense active list.
// Holds pool sizing constants, operation and status codes, sequencer states
// and the table access request type. No dependencies.
package sadl_pkg;

    // Pool sizing.
    localparam int POOL_SIZE = 1024;
    localparam int SLOT_W    = $clog2(POOL_SIZE);
    localparam int CNT_W     = $clog2(POOL_SIZE + 1);
    localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(POOL_SIZE);

    // Operation codes carried by a request.
    typedef enum logic [1:0] {
        FN_ALLOC   = 2'd0,
        FN_RELEASE = 2'd1,
        FN_READ    = 2'd2,
        FN_CLEAR   = 2'd3
    } t_func;

    // Status codes returned with each result.
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_INVALID = 2'd2
    } t_status;

    // Sequencer states of the top level.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ALLOC_WR,
        ST_REL_POS,
        ST_REL_CHK,
        ST_REL_LAST,
        ST_READ_OUT
    } t_state;

    // One write port and one read port of a slot table.
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [SLOT_W-1:0] wdata;
        logic [SLOT_W-1:0] raddr;
    } t_ram_req;

endpackage

@@ src/sadl_ram.sv @@
// Slot table: POOL_SIZE entries of one slot number each, one write and one
// registered read per cycle. Depends on sadl_pkg.
module sadl_ram (
    input  logic                  i_clk,
    input  sadl_pkg::t_ram_req    i_req,
    output logic [sadl_pkg::SLOT_W-1:0] o_rdata
);
    import sadl_pkg::*;

    // Two-state storage: entries never written read as zero.
    bit [SLOT_W-1:0] r_mem [POOL_SIZE];
    logic [SLOT_W-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/slot_allocator_dense_active_list_core.sv @@
// Top level of the slot allocator: sequencer, counters and three slot tables
// (free stack, active list, position of each slot). Depends on sadl_pkg and
// sadl_ram.
//
//   Channel   Direction  Handshake            Payload
//   request   in         start, busy          i_func, i_slot_id, i_list_index
//   result    out        o_valid (one cycle)  o_status, o_result_slot,
//                                             o_active_count
//
// Requests are taken only in idle, one at a time: busy stays high until the
// result of the last request is shown. Each table has a single registered
// read port, so a release makes three dependent reads in turn (position,
// owner check, last entry).
// Reset is synchronous; the pool is full and no slot is active afterwards.
// Clear takes effect at once: the free stack keeps a low-water mark, and
// entries below it read as their descending reset value.
// The result strobe lasts one cycle; the receiver cannot stall it.
module slot_allocator_dense_active_list_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_func,
    input  logic [sadl_pkg::SLOT_W-1:0]  i_slot_id,
    input  logic [sadl_pkg::SLOT_W-1:0]  i_list_index,
    output logic                         o_valid,
    output logic [1:0]                   o_status,
    output logic [sadl_pkg::SLOT_W-1:0]  o_result_slot,
    output logic [sadl_pkg::CNT_W-1:0]   o_active_count
);
    import sadl_pkg::*;

    t_state            r_state, n_state;
    t_func             r_func, n_func;
    logic [SLOT_W-1:0] r_slot_id, n_slot_id;
    logic [SLOT_W-1:0] r_list_index, n_list_index;
    logic [CNT_W-1:0]  r_total, n_total;
    logic [CNT_W-1:0]  r_low, n_low;
    logic [SLOT_W-1:0] r_pos, n_pos;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic              r_valid, n_valid;
    t_status           r_status, n_status;
    logic [SLOT_W-1:0] r_result, n_result;
    logic [CNT_W-1:0]  r_count, n_count;

    t_ram_req          fs_req, al_req, pt_req;
    logic [SLOT_W-1:0] fs_rdata, al_rdata, pt_rdata;

    logic [CNT_W-1:0]  w_free;
    logic              w_full;
    logic              w_read_bad;
    logic              w_pos_bad;
    logic              w_not_owner;
    logic              w_pristine;
    logic [SLOT_W-1:0] w_pop_id;
    logic              w_accept;

    // Slot tables.
    sadl_ram u_free_stack (.i_clk(i_clk), .i_req(fs_req), .o_rdata(fs_rdata));
    sadl_ram u_active    (.i_clk(i_clk), .i_req(al_req), .o_rdata(al_rdata));
    sadl_ram u_position  (.i_clk(i_clk), .i_req(pt_req), .o_rdata(pt_rdata));

    // Shared checks. Free slots and active slots always add up to the pool.
    assign w_accept    = start && (r_state == ST_IDLE);
    assign w_free      = POOL_CNT - r_total;
    assign w_full      = (r_total == POOL_CNT);
    assign w_read_bad  = ({1'b0, r_list_index} >= r_total);
    assign w_pos_bad   = ({1'b0, pt_rdata} >= r_total);
    assign w_not_owner = (al_rdata != r_slot_id);
    // Stack entries below the low-water mark were not written since clear.
    assign w_pristine  = ({1'b0, r_idx} < r_low);
    assign w_pop_id    = w_pristine ? SLOT_W'(POOL_CNT - CNT_W'(1) - {1'b0, r_idx})
                                    : fs_rdata;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (r_func)
                    FN_ALLOC:   n_state = w_full ? ST_IDLE : ST_ALLOC_WR;
                    FN_RELEASE: n_state = ST_REL_POS;
                    FN_READ:    n_state = w_read_bad ? ST_IDLE : ST_READ_OUT;
                    FN_CLEAR:   n_state = ST_IDLE;
                    default:    n_state = ST_IDLE;
                endcase
            end
            ST_REL_POS: n_state = w_pos_bad ? ST_IDLE : ST_REL_CHK;
            ST_REL_CHK: n_state = w_not_owner ? ST_IDLE : ST_REL_LAST;
            ST_ALLOC_WR, ST_REL_LAST, ST_READ_OUT: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Table accesses, counters and result.
    always_comb begin
        n_func       = r_func;
        n_slot_id    = r_slot_id;
        n_list_index = r_list_index;
        n_total      = r_total;
        n_low        = r_low;
        n_pos        = r_pos;
        n_idx        = r_idx;
        n_valid      = 1'b0;
        n_status     = r_status;
        n_result     = r_result;
        n_count      = r_count;
        fs_req       = '0;
        al_req       = '0;
        pt_req       = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_func       = t_func'(i_func);
                    n_slot_id    = i_slot_id;
                    n_list_index = i_list_index;
                end
            end
            ST_DECODE: begin
                unique case (r_func)
                    FN_ALLOC: begin
                        // Read the top of the free stack.
                        n_idx        = SLOT_W'(w_free - CNT_W'(1));
                        fs_req.raddr = SLOT_W'(w_free - CNT_W'(1));
                        if (w_full) begin
                            n_valid  = 1'b1;
                            n_status = STAT_EMPTY;
                            n_result = '0;
                            n_count  = r_total;
                        end
                    end
                    FN_RELEASE: begin
                        pt_req.raddr = r_slot_id;
                    end
                    FN_READ: begin
                        al_req.raddr = r_list_index;
                        if (w_read_bad) begin
                            n_valid  = 1'b1;
                            n_status = STAT_INVALID;
                            n_result = '0;
                            n_count  = r_total;
                        end
                    end
                    FN_CLEAR: begin
                        n_total  = '0;
                        n_low    = POOL_CNT;
                        n_valid  = 1'b1;
                        n_status = STAT_OK;
                        n_result = '0;
                        n_count  = '0;
                    end
                    default: begin
                        n_valid = 1'b0;
                    end
                endcase
            end
            ST_ALLOC_WR: begin
                // Append the popped slot to the active list.
                al_req.we    = 1'b1;
                al_req.waddr = r_total[SLOT_W-1:0];
                al_req.wdata = w_pop_id;
                pt_req.we    = 1'b1;
                pt_req.waddr = w_pop_id;
                pt_req.wdata = r_total[SLOT_W-1:0];
                n_total      = r_total + CNT_W'(1);
                if (w_pristine) begin
                    n_low = {1'b0, r_idx};
                end
                n_valid  = 1'b1;
                n_status = STAT_OK;
                n_result = w_pop_id;
                n_count  = r_total + CNT_W'(1);
            end
            ST_REL_POS: begin
                // The slot is active only if its recorded position points back to it.
                n_pos        = pt_rdata;
                al_req.raddr = pt_rdata;
                if (w_pos_bad) begin
                    n_valid  = 1'b1;
                    n_status = STAT_INVALID;
                    n_result = '0;
                    n_count  = r_total;
                end
            end
            ST_REL_CHK: begin
                al_req.raddr = SLOT_W'(r_total - CNT_W'(1));
                if (w_not_owner) begin
                    n_valid  = 1'b1;
                    n_status = STAT_INVALID;
                    n_result = '0;
                    n_count  = r_total;
                end
            end
            ST_REL_LAST: begin
                // Push the slot and move the last active entry into the hole.
                fs_req.we    = 1'b1;
                fs_req.waddr = w_free[SLOT_W-1:0];
                fs_req.wdata = r_slot_id;
                al_req.we    = 1'b1;
                al_req.waddr = r_pos;
                al_req.wdata = al_rdata;
                pt_req.we    = 1'b1;
                pt_req.waddr = al_rdata;
                pt_req.wdata = r_pos;
                n_total      = r_total - CNT_W'(1);
                n_valid      = 1'b1;
                n_status     = STAT_OK;
                n_result     = '0;
                n_count      = r_total - CNT_W'(1);
            end
            ST_READ_OUT: begin
                n_valid  = 1'b1;
                n_status = STAT_OK;
                n_result = al_rdata;
                n_count  = r_total;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    // Registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_total <= '0;
            r_low   <= POOL_CNT;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_low   <= n_low;
            r_valid <= n_valid;
        end
        r_func       <= n_func;
        r_slot_id    <= n_slot_id;
        r_list_index <= n_list_index;
        r_pos        <= n_pos;
        r_idx        <= n_idx;
        r_status     <= n_status;
        r_result     <= n_result;
        r_count      <= n_count;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_result_slot  = r_result;
    assign o_active_count = r_count;

endmodule

@@ src/sadl_checker.sv @@
// Port-level checks for the slot allocator, attached to the top level by
// the bind statement at the end. Depends on sadl_pkg.
module sadl_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_valid,
    input logic [1:0]                   o_status,
    input logic [sadl_pkg::SLOT_W-1:0]  o_result_slot,
    input logic [sadl_pkg::CNT_W-1:0]   o_active_count
);
    import sadl_pkg::*;

    // An accepted request makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an accepted request");

    // A result is shown only once the block is free again.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    // Each request gives a single one-cycle result.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // Failed requests return slot zero.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != STAT_OK)) |-> (o_result_slot == '0))
        else $error("nonzero slot on an error result");

    // The active count never exceeds the pool.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_active_count <= POOL_CNT))
        else $error("active count beyond pool size");

endmodule

bind slot_allocator_dense_active_list_core sadl_checker u_sadl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_status       (o_status),
    .o_result_slot  (o_result_slot),
    .o_active_count (o_active_count)
);

@@ tb/slot_alloc_checker.sv @@
// Checker for the slot allocator: watches the request and result channels,
// keeps its own copy of the free stack, active list and position table, and
// compares every result. Depends on sadl_pkg.
module slot_alloc_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [1:0]                   i_func,
    input  logic [sadl_pkg::SLOT_W-1:0]  i_slot_id,
    input  logic [sadl_pkg::SLOT_W-1:0]  i_list_index,
    input  logic                         o_valid,
    input  logic [1:0]                   o_status,
    input  logic [sadl_pkg::SLOT_W-1:0]  o_result_slot,
    input  logic [sadl_pkg::CNT_W-1:0]   o_active_count,
    output int                           o_fail_count,
    output int                           o_pending
);
    import sadl_pkg::*;

    // What one request should return.
    typedef struct {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  count;
    } t_alloc_result;

    // Shadow copy of the allocator state.
    logic [SLOT_W-1:0] free_stack   [POOL_SIZE];
    logic [CNT_W-1:0]  free_depth;
    logic [SLOT_W-1:0] active_slots [POOL_SIZE];
    logic [CNT_W-1:0]  active_total;
    logic [SLOT_W-1:0] slot_pos     [POOL_SIZE];
    bit                slot_taken   [POOL_SIZE];

    t_alloc_result     expected_results [$];
    int                mismatches;

    // Refill the free stack so that slot 0 sits on top, and drop every
    // active slot.
    function automatic void refill_pool();
        for (int i = 0; i < POOL_SIZE; i++) begin
            free_stack[i] = SLOT_W'(POOL_SIZE - 1 - i);
            slot_taken[i] = 1'b0;
        end
        free_depth   = POOL_CNT;
        active_total = '0;
    endfunction

    // Apply one request to the shadow state and return its result.
    function automatic t_alloc_result predict_request(t_func fn, logic [SLOT_W-1:0] sid,
                                                      logic [SLOT_W-1:0] lidx);
        t_alloc_result     r;
        logic [SLOT_W-1:0] hole;
        logic [SLOT_W-1:0] tail_slot;
        logic [CNT_W-1:0]  tail_idx;
        r.status = STAT_OK;
        r.slot   = '0;
        case (fn)
            FN_ALLOC: begin
                if (free_depth == '0 || active_total >= POOL_CNT) begin
                    r.status = STAT_EMPTY;
                end else begin
                    free_depth = free_depth - 1'b1;
                    r.slot = free_stack[free_depth[SLOT_W-1:0]];
                    active_slots[active_total[SLOT_W-1:0]] = r.slot;
                    slot_pos[r.slot] = active_total[SLOT_W-1:0];
                    slot_taken[r.slot] = 1'b1;
                    active_total = active_total + 1'b1;
                end
            end
            FN_RELEASE: begin
                if (!slot_taken[sid] || active_total == '0 || free_depth >= POOL_CNT) begin
                    r.status = STAT_INVALID;
                end else begin
                    // The last active entry moves into the hole left by the slot.
                    hole      = slot_pos[sid];
                    tail_idx  = active_total - 1'b1;
                    tail_slot = active_slots[tail_idx[SLOT_W-1:0]];
                    free_stack[free_depth[SLOT_W-1:0]] = sid;
                    free_depth = free_depth + 1'b1;
                    active_slots[hole]  = tail_slot;
                    slot_pos[tail_slot] = hole;
                    slot_taken[sid] = 1'b0;
                    active_total = tail_idx;
                end
            end
            FN_READ: begin
                if ({1'b0, lidx} >= active_total) begin
                    r.status = STAT_INVALID;
                end else begin
                    r.slot = active_slots[lidx];
                end
            end
            default: begin
                refill_pool();
            end
        endcase
        r.count = active_total;
        return r;
    endfunction

    // Results are checked before a request of the same edge is predicted,
    // since a result always belongs to an earlier request.
    always @(posedge i_clk) begin
        t_alloc_result want;
        if (!i_rst_n) begin
            refill_pool();
            expected_results.delete();
        end else begin
            if (o_valid === 1'b1) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        mismatches++;
                    end
                    if (o_result_slot !== want.slot) begin
                        $error("result_slot: expected %0d, got %0d", want.slot, o_result_slot);
                        mismatches++;
                    end
                    if (o_active_count !== want.count) begin
                        $error("active_count: expected %0d, got %0d",
                               want.count, o_active_count);
                        mismatches++;
                    end
                end
            end
            if (start && !busy) begin
                expected_results.insert(expected_results.size(),
                    predict_request(t_func'(i_func), i_slot_id, i_list_index));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_results.size();
    end

endmodule

@@ tb/tb_slot_allocator_dense_active_list_core.sv @@
// Testbench top for the slot allocator: drives requests in bursts and gives
// the verdict. Depends on sadl_pkg, slot_allocator_dense_active_list_core
// and slot_alloc_checker.
module tb_slot_allocator_dense_active_list_core;
    import sadl_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_func;
    logic [SLOT_W-1:0] i_slot_id;
    logic [SLOT_W-1:0] i_list_index;
    logic              o_valid;
    logic [1:0]        o_status;
    logic [SLOT_W-1:0] o_result_slot;
    logic [CNT_W-1:0]  o_active_count;
    int                fail_count;
    int                pending;

    // Rough upper bound of the slot numbers handed out since the last clear;
    // release and read targets are drawn mostly below it.
    int                slot_span;
    int                burst_left;

    slot_allocator_dense_active_list_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_slot_id      (i_slot_id),
        .i_list_index   (i_list_index),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_result_slot  (o_result_slot),
        .o_active_count (o_active_count)
    );

    slot_alloc_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_slot_id      (i_slot_id),
        .i_list_index   (i_list_index),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_result_slot  (o_result_slot),
        .o_active_count (o_active_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    // Present one request and hold it until accepted. Between bursts the
    // request line drops for a random number of cycles.
    task automatic issue_request(t_func fn, logic [SLOT_W-1:0] sid, logic [SLOT_W-1:0] lidx);
        int gap;
        start        <= 1'b1;
        i_func       <= fn;
        i_slot_id    <= sid;
        i_list_index <= lidx;
        do @(posedge i_clk); while (busy);
        if (fn == FN_ALLOC && slot_span < POOL_SIZE) slot_span++;
        if (fn == FN_CLEAR) slot_span = 0;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 7);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stop sending until every outstanding request has its result.
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Mostly a slot below the span, sometimes any 10-bit value.
    function automatic logic [SLOT_W-1:0] pick_slot(int span);
        if (span <= 0 || $urandom_range(0, 9) == 0) return SLOT_W'($urandom);
        return SLOT_W'($urandom_range(0, span - 1));
    endfunction

    initial begin
        int seg_left;
        int mode;
        int roll;
        start        = 1'b0;
        i_func       = FN_ALLOC;
        i_slot_id    = '0;
        i_list_index = '0;
        i_rst_n      = 1'b0;
        slot_span    = 0;
        burst_left   = $urandom_range(1, 12);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty reads, inactive releases, hole filling,
        // double release, clear and allocation right after clear.
        issue_request(FN_READ, '0, '0);
        issue_request(FN_READ, '1, '1);
        issue_request(FN_RELEASE, '0, '0);
        issue_request(FN_RELEASE, '1, '0);
        repeat (4) issue_request(FN_ALLOC, '1, '1);
        issue_request(FN_READ, '0, SLOT_W'(0));
        issue_request(FN_READ, '0, SLOT_W'(3));
        issue_request(FN_READ, '0, SLOT_W'(4));
        issue_request(FN_RELEASE, SLOT_W'(1), '0);
        issue_request(FN_READ, '0, SLOT_W'(1));
        issue_request(FN_RELEASE, SLOT_W'(1), '0);
        issue_request(FN_RELEASE, SLOT_W'(3), '0);
        issue_request(FN_RELEASE, SLOT_W'(0), '0);
        issue_request(FN_READ, '0, SLOT_W'(0));
        issue_request(FN_ALLOC, '0, '0);
        issue_request(FN_CLEAR, '0, '0);
        issue_request(FN_ALLOC, '0, '0);
        issue_request(FN_RELEASE, SLOT_W'(0), '0);
        issue_request(FN_READ, '0, '1);
        issue_request(FN_CLEAR, '1, '1);
        drain_results();

        // Allocate toward a full pool, with a read in about one of twenty requests.
        for (int i = 0; i < 1040; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                issue_request(FN_READ, SLOT_W'($urandom), pick_slot(slot_span + 1));
            end else begin
                issue_request(FN_ALLOC, SLOT_W'($urandom), SLOT_W'($urandom));
            end
        end
        issue_request(FN_READ, '0, '1);
        issue_request(FN_RELEASE, '1, '0);
        issue_request(FN_RELEASE, '0, '0);
        drain_results();

        // Mixed traffic in segments that grow, shrink or churn the pool.
        seg_left = 0;
        mode     = 0;
        for (int i = 0; i < 650; i++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(40, 150);
                mode     = $urandom_range(0, 2);
            end
            seg_left--;
            roll = $urandom_range(0, 99);
            if (mode == 0) begin
                if (roll < 60) issue_request(FN_ALLOC, SLOT_W'($urandom), SLOT_W'($urandom));
                else if (roll < 75) issue_request(FN_RELEASE, pick_slot(slot_span),
                                                  SLOT_W'($urandom));
                else issue_request(FN_READ, SLOT_W'($urandom), pick_slot(slot_span + 1));
            end else if (mode == 1) begin
                if (roll < 15) issue_request(FN_ALLOC, SLOT_W'($urandom), SLOT_W'($urandom));
                else if (roll < 75) issue_request(FN_RELEASE, pick_slot(slot_span),
                                                  SLOT_W'($urandom));
                else issue_request(FN_READ, SLOT_W'($urandom), pick_slot(slot_span + 1));
            end else begin
                if (roll < 35) issue_request(FN_ALLOC, SLOT_W'($urandom), SLOT_W'($urandom));
                else if (roll < 70) issue_request(FN_RELEASE, pick_slot(slot_span),
                                                  SLOT_W'($urandom));
                else if (roll < 98) issue_request(FN_READ, SLOT_W'($urandom),
                                                  pick_slot(slot_span + 1));
                else issue_request(FN_CLEAR, SLOT_W'($urandom), SLOT_W'($urandom));
            end
        end

        // Let the last results arrive and allow a few quiet cycles.
        drain_results();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
